@@ sv/assert_macros.svh @@
// Assertion helpers used by the RTL controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property holds at every rising clock edge out of reset.
`define BFFA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
// Expression must never be true out of reset.
`define BFFA_NEVER(lbl, clk, rstn, expr) \
  `BFFA_ASSERT(lbl, clk, rstn, !(expr))
`else
`define BFFA_ASSERT(lbl, clk, rstn, prop)
`define BFFA_NEVER(lbl, clk, rstn, expr)
`endif
`endif

@@ sv/bffa_pkg.sv @@
`default_nettype none
package bffa_pkg;

  // Bitmap storage word and geometry defaults
  localparam int WORD_BITS      = 8;
  localparam int WORD_SHIFT     = 3;
  localparam int DEF_NUM_UNITS  = 1024;
  localparam int DEF_UNIT_SHIFT = 12;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;
  localparam logic [1:0] ST_UNALLOC = 2'd3;

  // Register indexes
  localparam logic [1:0] CFG_BASE  = 2'd0;
  localparam logic [1:0] CFG_PHYS  = 2'd1;
  localparam logic [1:0] CFG_UNITS = 2'd2;

  // Request opcodes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic take;
    logic check;
    logic scan_rd;
    logic scan_ev;
    logic rng_rd;
    logic ver_ev;
    logic app_ev;
    logic clr_step;
    logic upd;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic cfg_clear;
    logic clr_last;
    logic chk_fail;
    logic need_zero;
    logic is_free;
    logic scan_found;
    logic scan_last;
    logic ver_bad;
    logic rng_last;
  } sts_t;

endpackage
`default_nettype wire

@@ sv/bffa_if.sv @@
`default_nettype none
// Request channel
interface bffa_req_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] req_size;
  logic [31:0] free_addr;
  modport source (output valid, op, req_size, free_addr, input ready);
  modport sink (input valid, op, req_size, free_addr, output ready);
endinterface

// Result channel
interface bffa_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] alloc_addr;
  logic [31:0] grant_pa;
  logic [22:0] free_bytes;
  modport source (output valid, status, alloc_addr, grant_pa, free_bytes, input ready);
  modport sink (input valid, status, alloc_addr, grant_pa, free_bytes, output ready);
endinterface
`default_nettype wire

@@ sv/bffa_ram.sv @@
`default_nettype none
module bffa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

@@ sv/bffa_ctrl.sv @@
`default_nettype none
`include "assert_macros.svh"
module bffa_ctrl import bffa_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  localparam logic [3:0] S_CLEAR   = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_CHECK   = 4'd2;
  localparam logic [3:0] S_SCAN_RD = 4'd3;
  localparam logic [3:0] S_SCAN_EV = 4'd4;
  localparam logic [3:0] S_VER_RD  = 4'd5;
  localparam logic [3:0] S_VER_EV  = 4'd6;
  localparam logic [3:0] S_APP_RD  = 4'd7;
  localparam logic [3:0] S_APP_EV  = 4'd8;
  localparam logic [3:0] S_UPD     = 4'd9;
  localparam logic [3:0] S_DONE    = 4'd10;

  logic [3:0] state_q, state_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_DONE);

  // Sequencer
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        if (sts_i.chk_fail) state_d = S_DONE;
        else if (!sts_i.is_free) state_d = S_SCAN_RD;
        else if (sts_i.need_zero) state_d = S_UPD;
        else state_d = S_VER_RD;
      end
      S_SCAN_RD: begin
        cmd_o.scan_rd = 1'b1;
        state_d       = S_SCAN_EV;
      end
      S_SCAN_EV: begin
        cmd_o.scan_ev = 1'b1;
        if (sts_i.scan_found) state_d = S_APP_RD;
        else if (sts_i.scan_last) state_d = S_DONE;
        else state_d = S_SCAN_RD;
      end
      S_VER_RD: begin
        cmd_o.rng_rd = 1'b1;
        state_d      = S_VER_EV;
      end
      S_VER_EV: begin
        cmd_o.ver_ev = 1'b1;
        if (sts_i.ver_bad) state_d = S_DONE;
        else if (sts_i.rng_last) state_d = S_APP_RD;
        else state_d = S_VER_RD;
      end
      S_APP_RD: begin
        cmd_o.rng_rd = 1'b1;
        state_d      = S_APP_EV;
      end
      S_APP_EV: begin
        cmd_o.app_ev = 1'b1;
        state_d      = sts_i.rng_last ? S_UPD : S_APP_RD;
      end
      S_UPD: begin
        cmd_o.upd = 1'b1;
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_CLEAR;
    endcase
    // a pool_units write restarts the bitmap sweep
    if (sts_i.cfg_clear) state_d = S_CLEAR;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  `BFFA_NEVER(a_no_take_busy, clk_i, rst_ni, out_valid_o && in_ready_o)
  `BFFA_ASSERT(a_take_check, clk_i, rst_ni, (in_valid_i && in_ready_o && !sts_i.cfg_clear) |=> (state_q == S_CHECK))
  `BFFA_ASSERT(a_done_hold, clk_i, rst_ni, (out_valid_o && !out_ready_i && !sts_i.cfg_clear) |=> out_valid_o)

endmodule
`default_nettype wire

@@ sv/bffa_dp.sv @@
`default_nettype none
module bffa_dp import bffa_pkg::*; #(
  parameter int NUM_UNITS  = DEF_NUM_UNITS,
  parameter int UNIT_SHIFT = DEF_UNIT_SHIFT
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        op_i,
  input  wire logic [31:0] req_size_i,
  input  wire logic [31:0] free_addr_i,
  output logic      [1:0]  status_o,
  output logic      [31:0] alloc_addr_o,
  output logic      [31:0] grant_pa_o,
  output logic      [22:0] free_bytes_o,
  input  wire cmd_t        cmd_i,
  output sts_t             sts_o
);

  localparam int CW = $clog2(NUM_UNITS + 1);
  localparam int NW = (NUM_UNITS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW = (NW > 1) ? $clog2(NW) : 1;
  localparam logic [32:0] RND = 33'((64'd1 << UNIT_SHIFT) - 64'd1);

  logic [31:0] base_q, phys_q, size_q, addr_q;
  logic [10:0] ucfg_q;
  logic [CW-1:0] free_q, need_q, lo_q, hi_q, run_q;
  logic [AW-1:0] wk_q;
  logic op_q;
  logic [1:0] status_q;
  logic [31:0] va_q, pa_q;
  logic [WORD_BITS-1:0] rdata, wdata, mask;

  logic [CW-1:0] units;
  logic [32:0] need33;
  logic fail_alloc, fail_free;
  logic [39:0] end_b, first40;
  logic [CW-1:0] first;
  logic [AW-1:0] last_word, lo_word, hi_word;
  logic [CW-1:0] run, start, u;
  logic found;
  logic [CW:0] free_sum;

  // Active unit count
  always_comb begin
    if (32'(ucfg_q) < 32'(NUM_UNITS)) units = CW'(ucfg_q);
    else units = CW'(NUM_UNITS);
  end

  // Request checks
  always_comb begin
    need33     = ({1'b0, size_q} + RND) >> UNIT_SHIFT;
    fail_alloc = (size_q == 32'd0) || ({32'd0, size_q} > (64'(free_q) << UNIT_SHIFT)) ||
                 (need33 > 33'(units));
    end_b      = 40'(base_q) + (40'(units) << UNIT_SHIFT);
    first40    = 40'(addr_q - base_q) >> UNIT_SHIFT;
    fail_free  = (units == '0) || (addr_q < base_q) || (40'(addr_q) >= end_b) ||
                 (40'(addr_q) + 40'(size_q) > end_b) ||
                 (first40 + 40'(need33) > 40'(units));
    first      = CW'(first40);
  end

  assign last_word = AW'((units - CW'(1)) >> WORD_SHIFT);
  assign lo_word   = AW'(lo_q >> WORD_SHIFT);
  assign hi_word   = AW'(hi_q >> WORD_SHIFT);

  // First-fit run search over one word
  always_comb begin
    run   = run_q;
    found = 1'b0;
    start = '0;
    u     = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      u = CW'({wk_q, WORD_SHIFT'(j)});
      if (!found) begin
        if (u >= units || rdata[j]) begin
          run = '0;
        end else begin
          run = run + CW'(1);
          if (run == need_q) begin
            found = 1'b1;
            start = u + CW'(1) - run;
          end
        end
      end
    end
  end

  // Range mask and write data for the current word
  always_comb begin
    mask = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      mask[j] = (CW'({wk_q, WORD_SHIFT'(j)}) >= lo_q) && (CW'({wk_q, WORD_SHIFT'(j)}) <= hi_q);
    end
    if (cmd_i.clr_step) wdata = '0;
    else if (op_q == OP_FREE) wdata = rdata & ~mask;
    else wdata = rdata | mask;
  end

  assign free_sum = {1'b0, free_q} + {1'b0, need_q};

  always_comb begin
    sts_o            = '0;
    sts_o.cfg_clear  = cfg_we_i && (cfg_idx_i == CFG_UNITS);
    sts_o.clr_last   = (wk_q == AW'(NW - 1));
    sts_o.chk_fail   = (op_q == OP_FREE) ? fail_free : fail_alloc;
    sts_o.need_zero  = (need33 == 33'd0);
    sts_o.is_free    = (op_q == OP_FREE);
    sts_o.scan_found = found;
    sts_o.scan_last  = (wk_q == last_word);
    sts_o.ver_bad    = ((rdata & mask) != mask);
    sts_o.rng_last   = (wk_q == hi_word);
  end

  // Configuration, free count and word pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
      phys_q <= '0;
      ucfg_q <= '0;
      free_q <= '0;
      wk_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_BASE:  base_q <= cfg_data_i;
          CFG_PHYS:  phys_q <= cfg_data_i;
          CFG_UNITS: begin
            ucfg_q <= cfg_data_i[10:0];
            if (32'(cfg_data_i[10:0]) < 32'(NUM_UNITS)) free_q <= CW'(cfg_data_i[10:0]);
            else free_q <= CW'(NUM_UNITS);
          end
          default: ;
        endcase
      end
      if (cmd_i.upd) begin
        if (op_q == OP_FREE) free_q <= (free_sum > {1'b0, units}) ? units : free_q + need_q;
        else free_q <= free_q - need_q;
      end
      // word pointer
      if (sts_o.cfg_clear) begin
        wk_q <= '0;
      end else if (cmd_i.clr_step) begin
        wk_q <= wk_q + AW'(1);
      end else if (cmd_i.check) begin
        wk_q <= (op_q == OP_FREE) ? AW'(first >> WORD_SHIFT) : '0;
      end else if (cmd_i.scan_ev) begin
        wk_q <= found ? AW'(start >> WORD_SHIFT) : wk_q + AW'(1);
      end else if (cmd_i.ver_ev) begin
        wk_q <= sts_o.rng_last ? lo_word : wk_q + AW'(1);
      end else if (cmd_i.app_ev && !sts_o.rng_last) begin
        wk_q <= wk_q + AW'(1);
      end
    end
  end

  // Request payload and working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      op_q   <= op_i;
      size_q <= req_size_i;
      addr_q <= free_addr_i;
    end
    if (cmd_i.check) begin
      need_q   <= CW'(need33);
      lo_q     <= first;
      hi_q     <= first + CW'(need33) - CW'(1);
      run_q    <= '0;
      va_q     <= '0;
      pa_q     <= '0;
      if (op_q == OP_FREE) status_q <= fail_free ? ST_RANGE : ST_OK;
      else status_q <= fail_alloc ? ST_NOSPACE : ST_OK;
    end
    if (cmd_i.scan_ev) begin
      run_q <= run;
      if (found) begin
        lo_q <= start;
        hi_q <= start + need_q - CW'(1);
      end else if (wk_q == last_word) begin
        status_q <= ST_NOSPACE;
      end
    end
    if (cmd_i.ver_ev && sts_o.ver_bad) status_q <= ST_UNALLOC;
    if (cmd_i.upd && op_q == OP_ALLOC) begin
      va_q <= base_q + 32'(64'(lo_q) << UNIT_SHIFT);
      pa_q <= phys_q + 32'(64'(lo_q) << UNIT_SHIFT);
    end
  end

  bffa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (NW)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (cmd_i.clr_step || cmd_i.app_ev),
    .waddr_i (wk_q),
    .wdata_i (wdata),
    .re_i    (cmd_i.scan_rd || cmd_i.rng_rd),
    .raddr_i (wk_q),
    .rdata_o (rdata)
  );

  assign status_o     = status_q;
  assign alloc_addr_o = va_q;
  assign grant_pa_o   = pa_q;
  assign free_bytes_o = 23'(64'(free_q) << UNIT_SHIFT);

endmodule
`default_nettype wire

@@ sv/bitmap_first_fit_allocator.sv @@
// Sequence: a request refused by the size or range check goes straight to the result; else
//   allocate scans 8-unit bitmap words up to the first fitting run, then
//   read-modify-writes the run's words; free checks and then clears the words of its range.
// Throughput: one request at a time; a new request is taken only in the idle state.
// Reset: asynchronous, active low; clears the config, free count, word pointer and state,
//   then sweeps the bitmap before the first request; a pool_units write repeats that sweep.
`default_nettype none
module bitmap_first_fit_allocator import bffa_pkg::*; #(
  parameter int NUM_UNITS  = DEF_NUM_UNITS,
  parameter int UNIT_SHIFT = DEF_UNIT_SHIFT
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  bffa_req_if.sink         in_req,
  bffa_rsp_if.source       out_rsp
);

  cmd_t cmd;
  sts_t sts;

  bffa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_req.valid),
    .in_ready_o  (in_req.ready),
    .out_valid_o (out_rsp.valid),
    .out_ready_i (out_rsp.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bffa_dp #(
    .NUM_UNITS  (NUM_UNITS),
    .UNIT_SHIFT (UNIT_SHIFT)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .op_i         (in_req.op),
    .req_size_i   (in_req.req_size),
    .free_addr_i  (in_req.free_addr),
    .status_o     (out_rsp.status),
    .alloc_addr_o (out_rsp.alloc_addr),
    .grant_pa_o   (out_rsp.grant_pa),
    .free_bytes_o (out_rsp.free_bytes),
    .cmd_i        (cmd),
    .sts_o        (sts)
  );

endmodule
`default_nettype wire

@@ test/bitmap_first_fit_allocator_tb.sv @@
`timescale 1ns / 100ps
`default_nettype none
module bitmap_first_fit_allocator_tb;
  import bffa_pkg::*;

  localparam int POOL_MAX   = 1024;
  localparam int USHIFT     = 12;
  localparam int WDOG_LIMIT = 20000;
  localparam int N_PHASES   = 8;
  localparam int PHASE_ITEMS = 160;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] va;
    logic [31:0] pa;
    logic [22:0] fbytes;
  } grant_t;

  typedef struct {
    logic        op;
    logic [31:0] size;
    logic [31:0] addr;
    bit          typed;
    grant_t      want;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = '0;
  logic [31:0] cfg_data = '0;

  bffa_req_if in_req ();
  bffa_rsp_if out_rsp ();

  bitmap_first_fit_allocator uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_req     (in_req.sink),
    .out_rsp    (out_rsp.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow allocator state
  bit          unit_used [POOL_MAX];
  logic [31:0] sh_base, sh_phys;
  logic [10:0] sh_units;
  longint      sh_free;

  grant_t      grant_q [$];
  logic [31:0] live_addr [$];
  logic [31:0] live_size [$];
  int          errors = 0;
  int          idle_cnt = 0;
  bit          no_idle = 1'b0;
  int          rsp_hold = 0;

  function automatic longint pool_len();
    return (sh_units < POOL_MAX) ? longint'(sh_units) : longint'(POOL_MAX);
  endfunction

  function automatic void shadow_cfg(logic [1:0] idx, logic [31:0] val);
    if (idx == CFG_BASE) begin
      sh_base = val;
    end else if (idx == CFG_PHYS) begin
      sh_phys = val;
    end else if (idx == CFG_UNITS) begin
      sh_units = val[10:0];
      foreach (unit_used[i]) unit_used[i] = 1'b0;
      sh_free = pool_len();
    end
  endfunction

  // Compute the grant for one request and update the shadow state
  function automatic grant_t alloc_step(logic op, logic [31:0] size, logic [31:0] addr);
    grant_t g;
    longint n, need, run, start, first, plen, lo;
    bit found;
    n = pool_len();
    need = (longint'(size) + 4095) >>> USHIFT;
    g = '0;
    found = 1'b0;
    start = 0;
    if (op == OP_ALLOC) begin
      if (size == 0 || longint'(size) > (sh_free <<< USHIFT) || need > n) begin
        g.status = ST_NOSPACE;
      end else begin
        run = 0;
        for (int i = 0; i < n; i++) begin
          if (unit_used[i]) begin
            run = 0;
          end else begin
            run++;
            if (run == need) begin
              start = i + 1 - run;
              found = 1'b1;
              break;
            end
          end
        end
        if (!found) g.status = ST_NOSPACE;
      end
      if (found) begin
        for (longint i = start; i < start + need; i++) unit_used[i] = 1'b1;
        sh_free -= need;
        g.va = sh_base + 32'(start <<< USHIFT);
        g.pa = sh_phys + 32'(start <<< USHIFT);
      end
    end else begin
      lo = longint'(sh_base);
      plen = n <<< USHIFT;
      if (n == 0 || longint'(addr) < lo || longint'(addr) >= lo + plen ||
          longint'(addr) + longint'(size) > lo + plen) begin
        g.status = ST_RANGE;
      end else begin
        first = (longint'(addr) - lo) >>> USHIFT;
        if (first + need > n) begin
          g.status = ST_RANGE;
        end else begin
          for (longint i = first; i < first + need; i++) begin
            if (!unit_used[i]) begin
              g.status = ST_UNALLOC;
              break;
            end
          end
          if (g.status == ST_OK) begin
            for (longint i = first; i < first + need; i++) unit_used[i] = 1'b0;
            sh_free += need;
            if (sh_free > n) sh_free = n;
          end
        end
      end
    end
    g.fbytes = 23'(sh_free <<< USHIFT);
    return g;
  endfunction

  // Drive one request; the grant is predicted at acceptance
  task automatic send_req(logic op, logic [31:0] size, logic [31:0] addr,
                          bit typed, grant_t want);
    int gap;
    grant_t g;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_req.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_req.valid     <= 1'b1;
    in_req.op        <= op;
    in_req.req_size  <= size;
    in_req.free_addr <= addr;
    @(posedge clk_i);
    while (!in_req.ready) @(posedge clk_i);
    g = alloc_step(op, size, addr);
    if (typed) g = want;
    grant_q.push_back(g);
    if (op == OP_ALLOC && g.status == ST_OK) begin
      live_addr.push_back(g.va);
      live_size.push_back(size);
    end
  endtask

  // Wait for all grants, then let the block settle before a register write
  task automatic drain();
    in_req.valid <= 1'b0;
    @(posedge clk_i);
    while (grant_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    shadow_cfg(idx, val);
    @(posedge clk_i);
  endtask

  task automatic setup_pool(logic [31:0] b, logic [31:0] p, logic [10:0] u);
    drain();
    write_reg(CFG_BASE, b);
    write_reg(CFG_PHYS, p);
    write_reg(CFG_UNITS, {21'd0, u});
    live_addr.delete();
    live_size.delete();
  endtask

  // Random request mix: mostly allocs and frees of live regions, some noise
  task automatic random_req();
    int sel, k, nu;
    logic [31:0] a, s;
    grant_t none;
    none = '0;
    sel = $urandom_range(0, 99);
    if (sel < 45) begin
      if ($urandom_range(0, 19) == 0) begin
        s = $urandom();
      end else begin
        nu = (pool_len() > 64 && $urandom_range(0, 3) == 0) ?
             $urandom_range(1, 64) : $urandom_range(1, 4);
        s = 32'((nu - 1) * 4096 + $urandom_range(1, 4096));
      end
      send_req(OP_ALLOC, s, 32'd0, 1'b0, none);
    end else if (sel < 85 && live_addr.size() != 0) begin
      k = $urandom_range(0, live_addr.size() - 1);
      a = live_addr[k];
      s = live_size[k];
      live_addr.delete(k);
      live_size.delete(k);
      if ($urandom_range(0, 9) == 0) begin
        a = a + 32'($urandom_range(0, 8191));
        s = $urandom_range(0, 12288);
      end
      send_req(OP_FREE, s, a, 1'b0, none);
    end else begin
      a = ($urandom_range(0, 1) == 0) ? $urandom() :
          sh_base + 32'($urandom_range(0, 32'(pool_len() * 4096 + 4096)));
      s = ($urandom_range(0, 1) == 0) ? $urandom() : $urandom_range(0, 16384);
      send_req(1'($urandom_range(0, 1)), s, a, 1'b0, none);
    end
  endtask

  // Result side: check against oldest grant, random stalls
  always @(posedge clk_i) begin
    if (out_rsp.valid && out_rsp.ready) begin
      if (grant_q.size() == 0) begin
        $display("%0t: unexpected result exp none got status=%0d", $time, out_rsp.status);
        errors++;
      end else begin
        grant_t e;
        e = grant_q.pop_front();
        if (out_rsp.status !== e.status) begin
          $display("%0t: status exp %0d got %0d", $time, e.status, out_rsp.status);
          errors++;
        end
        if (out_rsp.alloc_addr !== e.va) begin
          $display("%0t: alloc_addr exp %h got %h", $time, e.va, out_rsp.alloc_addr);
          errors++;
        end
        if (out_rsp.grant_pa !== e.pa) begin
          $display("%0t: grant_pa exp %h got %h", $time, e.pa, out_rsp.grant_pa);
          errors++;
        end
        if (out_rsp.free_bytes !== e.fbytes) begin
          $display("%0t: free_bytes exp %h got %h", $time, e.fbytes, out_rsp.free_bytes);
          errors++;
        end
      end
      rsp_hold = no_idle ? 0 : $urandom_range(0, 8);
    end
    if (rsp_hold > 0) begin
      rsp_hold--;
      out_rsp.ready <= 1'b0;
    end else begin
      out_rsp.ready <= 1'b1;
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((in_req.valid && in_req.ready) || (out_rsp.valid && out_rsp.ready))
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  dir_row_t dir_tab [$];

  function automatic dir_row_t row(logic op, logic [31:0] s, logic [31:0] a,
                                   bit t, logic [1:0] st, logic [22:0] fb);
    dir_row_t r;
    r.op = op;
    r.size = s;
    r.addr = a;
    r.typed = t;
    r.want = '{status: st, va: 32'd0, pa: 32'd0, fbytes: fb};
    return r;
  endfunction

  logic [31:0] pb [N_PHASES];
  logic [31:0] pp [N_PHASES];
  logic [10:0] pu [N_PHASES];

  initial begin
    in_req.valid     = 1'b0;
    in_req.op        = OP_ALLOC;
    in_req.req_size  = '0;
    in_req.free_addr = '0;
    out_rsp.ready    = 1'b0;
    sh_base = '0;
    sh_phys = '0;
    sh_units = '0;
    sh_free = 0;
    foreach (unit_used[i]) unit_used[i] = 1'b0;

    // No pool after reset
    dir_tab.push_back(row(OP_ALLOC, 32'd1, 32'd0, 1'b1, ST_NOSPACE, 23'd0));
    dir_tab.push_back(row(OP_FREE, 32'd4096, 32'd0, 1'b1, ST_RANGE, 23'd0));
    // 16-unit pool at the top of the address space
    dir_tab.push_back(row(OP_ALLOC, 32'd0, 32'd0, 1'b1, ST_NOSPACE, 23'd65536));
    dir_tab.push_back(row(OP_ALLOC, 32'hFFFF_FFFF, 32'd0, 1'b1, ST_NOSPACE, 23'd65536));
    dir_tab.push_back(row(OP_FREE, 32'd4096, 32'd0, 1'b1, ST_RANGE, 23'd65536));
    dir_tab.push_back(row(OP_ALLOC, 32'd1, 32'd0, 1'b0, ST_OK, 0));
    dir_tab.push_back(row(OP_ALLOC, 32'd4097, 32'd0, 1'b0, ST_OK, 0));
    dir_tab.push_back(row(OP_FREE, 32'd1, 32'hFFFF_FFFF, 1'b0, ST_OK, 0));
    dir_tab.push_back(row(OP_FREE, 32'd4096, 32'hFFFF_8000, 1'b0, ST_OK, 0));
    dir_tab.push_back(row(OP_FREE, 32'd0, 32'hFFFF_0000, 1'b0, ST_OK, 0));
    dir_tab.push_back(row(OP_FREE, 32'd4096, 32'hFFFF_0000, 1'b0, ST_OK, 0));
    dir_tab.push_back(row(OP_FREE, 32'd4096, 32'hFFFF_0000, 1'b0, ST_OK, 0));
    dir_tab.push_back(row(OP_FREE, 32'hFFFF_FFFF, 32'hFFFF_1000, 1'b0, ST_OK, 0));
    dir_tab.push_back(row(OP_ALLOC, 32'd65536, 32'd0, 1'b0, ST_OK, 0));
    dir_tab.push_back(row(OP_FREE, 32'd8192, 32'hFFFF_1000, 1'b0, ST_OK, 0));
    dir_tab.push_back(row(OP_ALLOC, 32'd53248, 32'd0, 1'b0, ST_OK, 0));
    dir_tab.push_back(row(OP_ALLOC, 32'd4096, 32'd0, 1'b0, ST_OK, 0));
    dir_tab.push_back(row(OP_FREE, 32'd65536, 32'hFFFF_0000, 1'b0, ST_OK, 0));
    dir_tab.push_back(row(OP_ALLOC, 32'd65536, 32'd0, 1'b0, ST_OK, 0));
    dir_tab.push_back(row(OP_ALLOC, 32'd1, 32'd0, 1'b0, ST_OK, 0));
    dir_tab.push_back(row(OP_FREE, 32'd65536, 32'hFFFF_0000, 1'b0, ST_OK, 0));

    pb = '{32'h4000_0000, 32'hFFFF_C000, 32'h0000_0000, 32'h0000_1000,
           32'h1234_5000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0040_0000};
    pp = '{32'h0000_0000, 32'hFFFF_F000, 32'hFFFF_FFFF, 32'h0000_2000,
           32'h0, 32'h0, 32'h0, 32'h0};
    pu = '{11'd32, 11'd8, 11'd1024, 11'd2047, 11'd0, 11'd64, 11'd1, 11'd24};
    pp[4] = $urandom();
    pb[6] = $urandom() & 32'hFFFF_F000;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    no_idle = 1'b1;
    foreach (dir_tab[i]) begin
      if (i == 2) setup_pool(32'hFFFF_0000, 32'hFFFF_F000, 11'd16);
      send_req(dir_tab[i].op, dir_tab[i].size, dir_tab[i].addr,
               dir_tab[i].typed, dir_tab[i].want);
    end

    // Random phases over several pool settings
    for (int ph = 0; ph < N_PHASES; ph++) begin
      setup_pool(pb[ph], pp[ph], pu[ph]);
      if (ph == 3) write_reg(2'd3, 32'hFFFF_FFFF);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        no_idle = (k >= 40 && k < 70);
        random_req();
      end
    end
    no_idle = 1'b0;

    drain();
    repeat (20) @(posedge clk_i);
    if (errors == 0 && grant_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ bitmap_first_fit_allocator.f @@
+incdir+sv
sv/bffa_pkg.sv
sv/bffa_if.sv
sv/bffa_ram.sv
sv/bffa_ctrl.sv
sv/bffa_dp.sv
sv/bitmap_first_fit_allocator.sv
test/bitmap_first_fit_allocator_tb.sv
